// File: hw/rtl/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// Shared constants, codes and types of the aging position table.
// ----------------------------------------------------------------------------
package apt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int MATCH_W  = 7;

	localparam logic [31:0] THR_RESET = 32'd540;
	localparam logic [31:0] ID_RESET  = 32'd1;

	// operation codes
	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_PICK   = 3'd2;
	localparam logic [2:0] MODE_TICK   = 3'd3;
	localparam logic [2:0] MODE_COUNT  = 3'd4;
	localparam logic [2:0] MODE_LOOKUP = 3'd5;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	// stored slot contents
	typedef struct packed {
		logic [31:0] id;
		logic [15:0] kind;
		logic [15:0] amount;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] owner;
		logic [31:0] timer;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// one input beat
	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] kind;
		logic [15:0] amount;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] owner;
		logic [31:0] lifetime;
		logic [31:0] entry_id;
		logic [15:0] requester;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        new_id;
		logic [15:0]        kind;
		logic [15:0]        amount;
		logic [15:0]        x;
		logic [15:0]        y;
		logic [15:0]        owner;
		logic [31:0]        timer;
		logic [MATCH_W-1:0] count;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_FIN,
		ST_RESP
	} state_t;

endpackage

// File: hw/rtl/apt_ram.sv
// ----------------------------------------------------------------------------
// apt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module apt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/apt_core.sv
// ----------------------------------------------------------------------------
// apt_core
// Slot sweep sequencer: reads every slot once per operation, updates timers
// on the fly, then commits the add/remove/pick and builds the result.
// ----------------------------------------------------------------------------
module apt_core import apt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cmd_t        cmd,
	input  logic [31:0] thr,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [IDX_W-1:0] addr_q;
	logic rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [CAPACITY-1:0] vld_q;
	logic free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic hit_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	entry_t hit_ent_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] id_ctr_q;
	res_t res_q;

	logic issue;
	logic last_addr;
	logic accept;

	entry_t rd_ent;
	logic [ENTRY_W-1:0] rd_data;
	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t ram_wdata;

	// per-slot evaluation
	logic slot_v, pos_hit, locked, take, tick_upd;
	entry_t new_ent;
	res_t res_d;

	assign accept    = in_valid && in_ready;
	assign last_addr = (addr_q == IDX_W'(CAPACITY - 1));
	assign rd_ent    = entry_t'(rd_data);

	apt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (issue),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SCAN;
			ST_SCAN: if (last_addr) state_d = ST_WAIT;
			ST_WAIT: state_d = ST_FIN;
			ST_FIN:  state_d = ST_RESP;
			ST_RESP: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		issue     = (state_q == ST_SCAN);
		res_valid = (state_q == ST_RESP);
	end

	assign res = res_q;

	// evaluate the slot whose data just came back
	always_comb begin
		slot_v   = rd_vld_s1 && vld_q[idx_s1];
		pos_hit  = slot_v && (rd_ent.x == cmd_q.pos_x) && (rd_ent.y == cmd_q.pos_y);
		locked   = (rd_ent.owner != 16'd0) && (rd_ent.timer > thr) &&
		           (rd_ent.owner != cmd_q.requester);
		tick_upd = (cmd_q.mode == MODE_TICK) && slot_v && (rd_ent.timer != 32'd0);
		case (cmd_q.mode)
			MODE_REMOVE, MODE_LOOKUP:
				take = slot_v && !hit_found_q && (rd_ent.id == cmd_q.entry_id);
			MODE_PICK:
				take = pos_hit && !locked &&
				       (!hit_found_q || (rd_ent.id < hit_ent_q.id));
			default:
				take = 1'b0;
		endcase
	end

	// entry built by add
	always_comb begin
		new_ent.id     = id_ctr_q;
		new_ent.kind   = cmd_q.kind;
		new_ent.amount = cmd_q.amount;
		new_ent.x      = cmd_q.pos_x;
		new_ent.y      = cmd_q.pos_y;
		new_ent.owner  = cmd_q.owner;
		new_ent.timer  = cmd_q.lifetime;
	end

	// RAM write: timer count-down during the sweep, add at commit
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = rd_ent;
		if (tick_upd) begin
			ram_we          = 1'b1;
			ram_wdata.timer = rd_ent.timer - 32'd1;
		end else if (state_q == ST_FIN && cmd_q.mode == MODE_ADD && free_found_q) begin
			ram_we    = 1'b1;
			ram_waddr = free_idx_q;
			ram_wdata = new_ent;
		end
	end

	// result of the finished sweep
	always_comb begin
		res_d        = '0;
		res_d.status = STAT_OK;
		case (cmd_q.mode)
			MODE_ADD: begin
				if (free_found_q) res_d.new_id = id_ctr_q;
				else res_d.status = STAT_FULL;
			end
			MODE_REMOVE: begin
				if (!hit_found_q) res_d.status = STAT_NOT_FOUND;
			end
			MODE_PICK: begin
				if (hit_found_q) begin
					res_d.kind   = hit_ent_q.kind;
					res_d.amount = hit_ent_q.amount;
				end else begin
					res_d.status = STAT_NOT_FOUND;
				end
			end
			MODE_COUNT: res_d.count = MATCH_W'(cnt_q);
			MODE_LOOKUP: begin
				if (hit_found_q) begin
					res_d.kind   = hit_ent_q.kind;
					res_d.amount = hit_ent_q.amount;
					res_d.x      = hit_ent_q.x;
					res_d.y      = hit_ent_q.y;
					res_d.owner  = hit_ent_q.owner;
					res_d.timer  = hit_ent_q.timer;
				end else begin
					res_d.status = STAT_NOT_FOUND;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			rd_vld_s1    <= 1'b0;
			vld_q        <= '0;
			free_found_q <= 1'b0;
			hit_found_q  <= 1'b0;
			cnt_q        <= '0;
			id_ctr_q     <= ID_RESET;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (accept) begin
				addr_q       <= '0;
				free_found_q <= 1'b0;
				hit_found_q  <= 1'b0;
				cnt_q        <= '0;
			end else begin
				if (issue) addr_q <= addr_q + IDX_W'(1);
				if (rd_vld_s1 && !vld_q[idx_s1] && !free_found_q) free_found_q <= 1'b1;
				if (take) hit_found_q <= 1'b1;
				if (pos_hit) cnt_q <= cnt_q + CNT_W'(1);
			end
			// expiry during tick
			if (tick_upd && rd_ent.timer == 32'd1) vld_q[idx_s1] <= 1'b0;
			// commit
			if (state_q == ST_FIN) begin
				case (cmd_q.mode)
					MODE_ADD: begin
						if (free_found_q) begin
							vld_q[free_idx_q] <= 1'b1;
							id_ctr_q          <= id_ctr_q + 32'd1;
						end
					end
					MODE_REMOVE, MODE_PICK: begin
						if (hit_found_q) vld_q[hit_idx_q] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) cmd_q <= cmd;
		idx_s1 <= addr_q;
		if (rd_vld_s1 && !vld_q[idx_s1] && !free_found_q) free_idx_q <= idx_s1;
		if (take) begin
			hit_idx_q <= idx_s1;
			hit_ent_q <= rd_ent;
		end
		if (state_q == ST_FIN) res_q <= res_d;
	end

endmodule

// File: hw/rtl/aging_position_table_unit.sv
// ----------------------------------------------------------------------------
// aging_position_table_unit
// Table of aging, positioned entries with add, remove, pick, tick, count
// and lookup operations, APB threshold register and registered output.
// ----------------------------------------------------------------------------
// Every operation sweeps all CAPACITY slots of the entry RAM, one slot per
// cycle through its single read port, then commits and forms the result.
// A new item is accepted only once the previous result has been handed to
// the output register; the core takes no item while a sweep is in progress.
// The output register holds a finished result while the next item is
// swept. No clearing pass is needed after reset.
module aging_position_table_unit import apt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [15:0]        kind,
	input  logic [15:0]        amount,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [15:0]        owner,
	input  logic [31:0]        lifetime,
	input  logic [31:0]        entry_id,
	input  logic [15:0]        requester,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [31:0]        new_id,
	output logic [15:0]        got_kind,
	output logic [15:0]        got_amount,
	output logic signed [15:0] got_x,
	output logic signed [15:0] got_y,
	output logic [15:0]        got_owner,
	output logic [31:0]        got_timer,
	output logic [MATCH_W-1:0] match_count
);

	logic [31:0] thr_q;
	cmd_t cmd;
	res_t res;
	res_t out_q;
	logic out_valid_q;
	logic res_valid;
	logic res_ready;

	// threshold register, single register at address zero
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? thr_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			thr_q <= pwdata;
		end
	end

	// input beat
	always_comb begin
		cmd.mode      = mode;
		cmd.kind      = kind;
		cmd.amount    = amount;
		cmd.pos_x     = pos_x;
		cmd.pos_y     = pos_y;
		cmd.owner     = owner;
		cmd.lifetime  = lifetime;
		cmd.entry_id  = entry_id;
		cmd.requester = requester;
	end

	apt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.thr       (thr_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign new_id      = out_q.new_id;
	assign got_kind    = out_q.kind;
	assign got_amount  = out_q.amount;
	assign got_x       = out_q.x;
	assign got_y       = out_q.y;
	assign got_owner   = out_q.owner;
	assign got_timer   = out_q.timer;
	assign match_count = out_q.count;

endmodule
